[rtl/core/dlt_pkg.sv]
// dlt_pkg: shared types and constants for the dense tanh layer.
// Holds command codes, fixed field widths, the tanh threshold table and the
// request/response structs between the top level and the tanh unit.
package dlt_pkg;

  // Fixed field widths
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 16;
  localparam int ACT_W  = 14;
  localparam int CFG_W  = 7;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register decode: byte address 4*i, so bit 2 selects the register
  localparam int   REG_SEL_BIT     = 2;
  localparam logic REG_NUM_INPUTS  = 1'b0;
  localparam logic REG_NUM_OUTPUTS = 1'b1;

  localparam int RST_NUM_INPUTS  = 10;
  localparam int RST_NUM_OUTPUTS = 5;

  // 0.1 in Q4.12
  localparam logic signed [VAL_W-1:0] INIT_ACT = 16'sd410;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_WEIGHT = 2'd0,
    CMD_WR_INPUT  = 2'd1,
    CMD_RUN       = 2'd2
  } cmd_e;

  // tanh unit: result k counts thresholds T[m] <= |sum|, with
  // T[m] = ceil(atanh((m + 0.5) / 4096) * 2^24), m = 0..4095.
  localparam int ACT_ONE    = 4096;
  localparam int TANH_STEPS = 4096;
  localparam int ROM_AW     = 12;
  localparam int K_W        = ROM_AW + 1;
  localparam int BIT_W      = 4;
  localparam int THR_W      = 27;
  // |sum| at or above 5.0 always gives full scale
  localparam int TANH_SAT   = 5 << 24;

  typedef logic [THR_W-1:0] thr_table_t [TANH_STEPS];

  // filled in rows of 64 entries to keep each loop short
  function automatic thr_table_t build_thr_table();
    thr_table_t t;
    real        x;
    real        a;
    int         m;
    for (int hi = 0; hi < TANH_STEPS / 64; hi++) begin
      for (int lo = 0; lo < 64; lo++) begin
        m    = hi * 64 + lo;
        x    = (real'(m) + 0.5) / 4096.0;
        a    = $atanh(x) * 16777216.0;
        t[m] = THR_W'($rtoi($ceil(a)));
      end
    end
    return t;
  endfunction

  localparam thr_table_t THR_TABLE = build_thr_table();

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [THR_W-1:0] mag;
  } tanh_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACT_W-1:0] act;
  } tanh_resp_t;

endpackage

[rtl/core/dlt_tanh.sv]
// dlt_tanh: tanh of a Q.24 magnitude to Q2.12 by binary search over a
// registered threshold ROM. Depends on dlt_pkg (table, request/response types).
module dlt_tanh (
  input  logic                clk,
  input  logic                rst,
  input  dlt_pkg::tanh_req_t  req,
  output dlt_pkg::tanh_resp_t resp
);
  import dlt_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_LOOK, T_CMP, T_FIN} tstate_t;

  tstate_t           state;
  logic              neg;
  logic [THR_W-1:0]  mag;
  logic [K_W-1:0]    k;
  logic [BIT_W-1:0]  bitn;
  logic [K_W-1:0]    cand;
  logic              skip;
  logic [ROM_AW-1:0] rom_addr;
  logic [THR_W-1:0]  rom_q;

  // probe entry k + 2^bitn; beyond the table it cannot be taken
  assign cand     = k + (K_W'(1) << bitn);
  assign skip     = cand > K_W'(TANH_STEPS);
  assign rom_addr = ROM_AW'(cand - K_W'(1));

  always_ff @(posedge clk) begin
    rom_q <= THR_TABLE[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      resp  <= '0;
    end else begin
      resp.done <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (req.start) begin
            neg   <= req.neg;
            mag   <= req.mag;
            k     <= '0;
            bitn  <= BIT_W'(ROM_AW);
            state <= T_LOOK;
          end
        end
        T_LOOK: begin
          if (skip) begin
            if (bitn == '0) state <= T_FIN;
            else bitn <= bitn - BIT_W'(1);
          end else begin
            state <= T_CMP;
          end
        end
        T_CMP: begin
          if (rom_q <= mag) k <= cand;
          if (bitn == '0) begin
            state <= T_FIN;
          end else begin
            bitn  <= bitn - BIT_W'(1);
            state <= T_LOOK;
          end
        end
        T_FIN: begin
          resp.done <= 1'b1;
          resp.act  <= neg ? -ACT_W'(k) : ACT_W'(k);
          state     <= T_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/dense_layer_tanh.sv]
// dense_layer_tanh: fully connected layer with tanh activation, Q4.12.
// A run handles one neuron at a time: one MAC walks one product a cycle
// (3-stage pipe), then the tanh unit does its 13-step ROM search, and the
// result waits out any output stall. Reset clears control, sets num_inputs
// 10 / num_outputs 5 and makes all input activations read 0.1; weights are
// undefined until written.
module dense_layer_tanh #(
  parameter int MAX_INPUTS  = 64,
  parameter int MAX_OUTPUTS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dlt_pkg::APB_AW-1:0]        paddr,
  input  logic [dlt_pkg::APB_DW-1:0]        pwdata,
  output logic [dlt_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dlt_pkg::CMD_W-1:0]         cmd,
  input  logic [dlt_pkg::IDX_W-1:0]         neuron,
  input  logic [dlt_pkg::IDX_W-1:0]         slot,
  input  logic signed [dlt_pkg::VAL_W-1:0]  value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dlt_pkg::IDX_W-1:0]         neuron_out,
  output logic signed [dlt_pkg::ACT_W-1:0]  activation,
  output logic                              last
);
  import dlt_pkg::*;

  localparam int IW    = $clog2(MAX_INPUTS);
  localparam int OW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int WA_W  = OW + IW;
  localparam int ACC_W = 2 * VAL_W + IW;

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_TANH, S_OUT} state_t;

  state_t                   state;
  logic [CFG_W-1:0]         num_in;
  logic [CFG_W-1:0]         num_out;
  logic [CFG_W-1:0]         j;
  logic [CFG_W-1:0]         oi;
  logic [IW-1:0]            j_idx;
  logic [OW-1:0]            oi_idx;
  logic                     issue;
  logic                     is_last;

  // config port
  logic                     cfg_wr;
  logic [CFG_W-1:0]         wdat;
  logic [CFG_W-1:0]         in_lim;
  logic [CFG_W-1:0]         out_lim;

  // request decode
  cmd_e                     cmd_c;
  logic                     in_acc;
  logic                     wr_w;
  logic                     wr_i;
  logic                     run;

  // storage and MAC pipe
  logic [VAL_W-1:0]         wmem [2**WA_W];
  logic [VAL_W-1:0]         imem [MAX_INPUTS];
  logic [MAX_INPUTS-1:0]    ivld;
  logic [VAL_W-1:0]         w_q;
  logic [VAL_W-1:0]         i_q;
  logic                     iv_q;
  logic signed [VAL_W-1:0]  act_op;
  logic signed [2*VAL_W-1:0] prod;
  logic                     p1;
  logic                     p2;
  logic signed [ACC_W-1:0]  acc;
  logic                     acc_neg;
  logic [ACC_W-1:0]         acc_mag;
  logic [THR_W-1:0]         req_mag;

  tanh_req_t                treq;
  tanh_resp_t               tresp;
  logic signed [ACT_W-1:0]  act_hold;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign wdat    = pwdata[CFG_W-1:0];
  assign in_lim  = (int'(wdat) > MAX_INPUTS)  ? CFG_W'(MAX_INPUTS)  : wdat;
  assign out_lim = (int'(wdat) > MAX_OUTPUTS) ? CFG_W'(MAX_OUTPUTS) : wdat;
  assign prdata  = (paddr[REG_SEL_BIT] == REG_NUM_OUTPUTS) ? APB_DW'(num_out)
                                                           : APB_DW'(num_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_in  <= CFG_W'(RST_NUM_INPUTS);
      num_out <= CFG_W'(RST_NUM_OUTPUTS);
    end else if (cfg_wr) begin
      unique case (paddr[REG_SEL_BIT])
        REG_NUM_INPUTS:  num_in  <= in_lim;
        REG_NUM_OUTPUTS: num_out <= out_lim;
      endcase
    end
  end

  // ---------------- request decode ----------------
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cmd_c    = cmd_e'(cmd);

  always_comb begin
    wr_w = 1'b0;
    wr_i = 1'b0;
    run  = 1'b0;
    unique case (cmd_c)
      CMD_WR_WEIGHT: wr_w = in_acc && (CFG_W'(neuron) < num_out) &&
                            (CFG_W'(slot) < num_in);
      CMD_WR_INPUT:  wr_i = in_acc && (CFG_W'(slot) < num_in);
      CMD_RUN:       run  = in_acc;
      default:       ;
    endcase
  end

  // ---------------- storage ----------------
  assign j_idx  = IW'(j);
  assign oi_idx = OW'(oi);
  assign issue  = (state == S_MAC) && (j < num_in);

  always_ff @(posedge clk) begin
    if (wr_w) wmem[{OW'(neuron), IW'(slot)}] <= value;
    w_q <= wmem[{oi_idx, j_idx}];
  end

  always_ff @(posedge clk) begin
    if (wr_i) imem[IW'(slot)] <= value;
    i_q <= imem[j_idx];
  end

  // an input slot never written reads as 0.1
  always_ff @(posedge clk) begin
    if (rst) ivld <= '0;
    else if (wr_i) ivld[IW'(slot)] <= 1'b1;
  end

  // ---------------- MAC pipe: read, multiply, accumulate ----------------
  assign act_op = iv_q ? $signed(i_q) : INIT_ACT;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
    end else begin
      p1 <= issue;
      p2 <= p1;
    end
    iv_q <= ivld[j_idx];
    prod <= act_op * $signed(w_q);
  end

  assign acc_neg = acc[ACC_W-1];
  assign acc_mag = acc_neg ? ACC_W'(-acc) : ACC_W'(acc);
  assign req_mag = (acc_mag >= ACC_W'(TANH_SAT)) ? THR_W'(TANH_SAT)
                                                 : acc_mag[THR_W-1:0];
  assign is_last = (oi + CFG_W'(1)) == num_out;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      treq      <= '0;
    end else begin
      treq.start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (p2) acc <= acc + ACC_W'(prod);
      unique case (state)
        S_IDLE: begin
          if (run && (num_out != '0)) begin
            oi    <= '0;
            j     <= '0;
            acc   <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (issue) j <= j + CFG_W'(1);
          else state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!p1 && !p2) begin
            treq.start <= 1'b1;
            treq.neg   <= acc_neg;
            treq.mag   <= req_mag;
            state      <= S_TANH;
          end
        end
        S_TANH: begin
          if (tresp.done) begin
            act_hold <= tresp.act;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            neuron_out <= IDX_W'(oi);
            activation <= act_hold;
            last       <= is_last;
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              oi    <= oi + CFG_W'(1);
              j     <= '0;
              acc   <= '0;
              state <= S_MAC;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  dlt_tanh u_tanh (
    .clk  (clk),
    .rst  (rst),
    .req  (treq),
    .resp (tresp)
  );

  // ---------------- assertions ----------------
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> (!p1 && !p2))
    else $error("MAC pipe not empty while taking requests");

  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result loaded outside output state");

  a_act_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (activation <= ACT_ONE) && (activation >= -ACT_ONE))
    else $error("activation out of range");

  a_tanh_done: assert property (@(posedge clk) disable iff (rst)
    tresp.done |-> (state == S_TANH))
    else $error("tanh result while not waiting for it");

endmodule

[tb/sv/dense_layer_tanh_tb.sv]
// Self-checking testbench for dense_layer_tanh: drives weight, input and run
// requests, predicts every neuron's Q2.12 tanh result and compares in order.
// Depends on dlt_pkg for field widths, command codes and register decode.
module dense_layer_tanh_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dlt_pkg::*;

  localparam int MAX_IN        = 64;
  localparam int MAX_OUT       = 64;
  localparam int SETTLE_CYCLES = 120;
  localparam int WATCHDOG      = 4000;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam bit [63:0]        Q48_UNIT   = 64'd1 << 48;

  typedef struct packed {
    logic [CMD_W-1:0]        op;
    logic [IDX_W-1:0]        nrn;
    logic [IDX_W-1:0]        slt;
    logic signed [VAL_W-1:0] val;
  } layer_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]        nrn;
    logic signed [ACT_W-1:0] act;
    logic                    lst;
  } neuron_res_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_AW-1:0]        paddr = '0;
  logic [APB_DW-1:0]        pwdata = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         cmd = '0;
  logic [IDX_W-1:0]         neuron = '0;
  logic [IDX_W-1:0]         slot = '0;
  logic signed [VAL_W-1:0]  value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [IDX_W-1:0]         neuron_out;
  logic signed [ACT_W-1:0]  activation;
  logic                     last;

  dense_layer_tanh uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .neuron(neuron), .slot(slot), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .neuron_out(neuron_out), .activation(activation), .last(last)
  );

  always #5 clk = ~clk;

  // Shadow of the layer state
  logic signed [VAL_W-1:0] w_mem [MAX_OUT][MAX_IN];
  logic signed [VAL_W-1:0] x_mem [MAX_IN];
  bit                      w_seen [MAX_OUT][MAX_IN];
  int                      n_in;
  int                      n_out;

  layer_req_t  pending_reqs [$];
  neuron_res_t expected_acts [$];

  int idle_pct   = 0;
  int n_queued   = 0;
  int n_accepted = 0;
  int n_runs     = 0;
  int n_results  = 0;
  int n_settings = 1;
  int mismatches = 0;
  int src_gap    = 0;
  int sink_gap   = 0;
  int quiet      = 0;

  // (a*b) >> 48 on a full 128-bit product, kept to 64 bits
  function automatic bit [63:0] mul_q48(bit [63:0] a, bit [63:0] b);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[111:48];
  endfunction

  // e^f for f in [0,1], Q16.48, 31-term series
  function automatic bit [63:0] exp_series(bit [63:0] f);
    bit [63:0] term;
    bit [63:0] total;
    term  = Q48_UNIT;
    total = Q48_UNIT;
    for (int i = 1; i <= 30; i++) begin
      term  = mul_q48(term, f) / 64'(i);
      total += term;
    end
    return total;
  endfunction

  // round(tanh(s / 2^24) * 4096) from the exact Q.24 dot product
  function automatic logic signed [ACT_W-1:0] tanh_fixed(longint s);
    bit [63:0]               mag;
    bit [63:0]               y;
    bit [63:0]               e;
    bit [63:0]               e1;
    bit [63:0]               d;
    bit [63:0]               num;
    bit [63:0]               den;
    bit [63:0]               k;
    logic signed [ACT_W-1:0] r;
    mag = (s < 0) ? 64'(-s) : 64'(s);
    if (mag >= (64'd5 << 24)) begin
      k = 64'd4096;
    end else begin
      y  = mag << 1;
      e  = exp_series({16'd0, y[23:0], 24'd0});
      e1 = exp_series(Q48_UNIT);
      for (int j = 0; j < int'(y >> 24); j++)
        e = mul_q48(e, e1);
      d   = e >> 12;
      num = 64'd8193 * d - 64'd8191 * (64'd1 << 36);
      den = 64'd2 * d + (64'd2 << 36);
      k   = num / den;
      if (k > 64'd4096)
        k = 64'd4096;
    end
    r = ACT_W'(k);
    return (s < 0) ? -r : r;
  endfunction

  // Update the shadow state for one accepted request, queue any results
  function automatic void apply_request(layer_req_t r);
    longint      acc;
    neuron_res_t res;
    if (r.op == CMD_WR_WEIGHT) begin
      if (int'(r.nrn) < n_out && int'(r.slt) < n_in)
        w_mem[r.nrn][r.slt] = r.val;
    end else if (r.op == CMD_WR_INPUT) begin
      if (int'(r.slt) < n_in)
        x_mem[r.slt] = r.val;
    end else if (r.op == CMD_RUN) begin
      n_runs++;
      for (int i = 0; i < n_out; i++) begin
        acc = 0;
        for (int j = 0; j < n_in; j++)
          acc += longint'(x_mem[j]) * longint'(w_mem[i][j]);
        res.nrn = IDX_W'(i);
        res.act = tanh_fixed(acc);
        res.lst = (i == n_out - 1);
        expected_acts.push_back(res);
      end
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return VAL_W'($urandom);
      1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return VAL_W'($urandom_range(0, 8192)) - 16'sd4096;
    endcase
  endfunction

  // A run never reads a weight that was not written: fill gaps first
  function automatic void queue_request(layer_req_t r);
    layer_req_t w;
    if (r.op == CMD_RUN) begin
      for (int i = 0; i < n_out; i++) begin
        for (int j = 0; j < n_in; j++) begin
          if (!w_seen[i][j]) begin
            w_seen[i][j] = 1'b1;
            w.op  = CMD_WR_WEIGHT;
            w.nrn = IDX_W'(i);
            w.slt = IDX_W'(j);
            w.val = rand_value();
            pending_reqs.push_back(w);
            n_queued++;
          end
        end
      end
    end else if (r.op == CMD_WR_WEIGHT && int'(r.nrn) < n_out && int'(r.slt) < n_in) begin
      w_seen[r.nrn][r.slt] = 1'b1;
    end
    pending_reqs.push_back(r);
    n_queued++;
  endfunction

  function automatic void queue_fields(logic [CMD_W-1:0] op, int nrn, int slt,
                                       logic signed [VAL_W-1:0] val);
    layer_req_t r;
    r.op  = op;
    r.nrn = IDX_W'(nrn);
    r.slt = IDX_W'(slt);
    r.val = val;
    queue_request(r);
  endfunction

  // Mostly in-range writes and runs with random content, some noise
  function automatic layer_req_t rand_request();
    layer_req_t  r;
    int unsigned pick;
    pick  = $urandom_range(0, 99);
    r.op  = CMD_WR_INPUT;
    r.nrn = IDX_W'($urandom);
    r.slt = IDX_W'($urandom);
    r.val = rand_value();
    if (pick < 38) begin
      r.op = CMD_WR_WEIGHT;
      if (n_in > 0 && n_out > 0) begin
        r.nrn = IDX_W'($urandom_range(0, n_out - 1));
        r.slt = IDX_W'($urandom_range(0, n_in - 1));
      end
    end else if (pick < 76) begin
      if (n_in > 0)
        r.slt = IDX_W'($urandom_range(0, n_in - 1));
    end else if (pick < 88) begin
      r.op = CMD_RUN;
    end else if (pick < 94) begin
      r.op = CMD_UNUSED;
    end else begin
      r.op = pick[0] ? CMD_WR_INPUT : CMD_WR_WEIGHT;
    end
    return r;
  endfunction

  task automatic set_reg(logic sel, int unsigned v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(sel) << REG_SEL_BIT;
    pwdata  <= APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    v = v & 32'h7F;
    if (sel == REG_NUM_INPUTS)
      n_in = (v > MAX_IN) ? MAX_IN : int'(v);
    else
      n_out = (v > MAX_OUT) ? MAX_OUT : int'(v);
  endtask

  // Wait until every request is taken and every result has come back
  task automatic drain();
    while (n_accepted != n_queued || expected_acts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned cfg_in, int unsigned cfg_out, int count, int pct);
    set_reg(REG_NUM_INPUTS, cfg_in);
    set_reg(REG_NUM_OUTPUTS, cfg_out);
    n_settings++;
    idle_pct = pct;
    repeat (count) queue_request(rand_request());
    queue_fields(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63), rand_value());
    drain();
  endtask

  // Request driver
  always @(posedge clk) begin : src
    layer_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      src_gap  <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request({cmd, neuron, slot, value});
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (src_gap != 0) begin
          in_valid <= 1'b0;
          src_gap  <= src_gap - 1;
        end else if (pending_reqs.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
          in_valid <= 1'b0;
          src_gap  <= $urandom_range(0, 13);
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          in_valid <= 1'b1;
          cmd      <= nxt.op;
          neuron   <= nxt.nrn;
          slot     <= nxt.slt;
          value    <= nxt.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and output stall generator
  always @(posedge clk) begin : sink
    neuron_res_t want;
    if (rst) begin
      out_stall <= 1'b0;
      sink_gap  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_acts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: neuron %0d act %0d last %0d",
                     neuron_out, activation, last);
        end else begin
          want = expected_acts.pop_front();
          if (neuron_out !== want.nrn || activation !== want.act || last !== want.lst) begin
            mismatches++;
            if (mismatches <= 10)
              $display("bad result: got neuron %0d act %0d last %0d, want %0d %0d %0d",
                       neuron_out, activation, last, want.nrn, want.act, want.lst);
          end
        end
      end
      if (sink_gap != 0) begin
        out_stall <= 1'b1;
        sink_gap  <= sink_gap - 1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_stall <= 1'b1;
        sink_gap  <= $urandom_range(0, 13);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Ends the run if neither side moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("timeout: no request or result moved for %0d cycles", WATCHDOG);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    for (int i = 0; i < MAX_OUT; i++)
      for (int j = 0; j < MAX_IN; j++)
        w_mem[i][j] = '0;
    for (int j = 0; j < MAX_IN; j++)
      x_mem[j] = INIT_ACT;
    n_in     = RST_NUM_INPUTS;
    n_out    = RST_NUM_OUTPUTS;
    idle_pct = 15;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes, untouched inputs first; sender holds off mid-way until
    // all results are back
    queue_fields(CMD_RUN, 0, 0, '0);
    repeat (10) queue_request(rand_request());
    queue_fields(CMD_RUN, 63, 63, 16'shFFFF);
    drain();
    repeat (10) queue_request(rand_request());
    queue_fields(CMD_RUN, 0, 0, '0);
    drain();

    // Directed: 2 inputs x 2 neurons
    set_reg(REG_NUM_INPUTS, 2);
    set_reg(REG_NUM_OUTPUTS, 2);
    n_settings++;
    queue_fields(CMD_WR_WEIGHT, 0, 0, 16'sh7FFF);
    queue_fields(CMD_WR_WEIGHT, 0, 1, 16'sh7FFF);
    queue_fields(CMD_WR_WEIGHT, 1, 0, 16'sh8000);
    queue_fields(CMD_WR_WEIGHT, 1, 1, 16'sh8000);
    queue_fields(CMD_WR_INPUT, 0, 0, 16'sh7FFF);
    queue_fields(CMD_WR_INPUT, 0, 1, 16'sh8000);
    queue_fields(CMD_RUN, 0, 0, '0);
    queue_fields(CMD_WR_INPUT, 0, 1, 16'sh7FFF);
    queue_fields(CMD_RUN, 0, 0, '0);              // both neurons saturate
    queue_fields(CMD_WR_WEIGHT, 63, 63, 16'shFFFF);  // out of range, ignored
    queue_fields(CMD_WR_WEIGHT, 2, 0, 16'sd1);
    queue_fields(CMD_WR_WEIGHT, 0, 2, 16'sd1);
    queue_fields(CMD_WR_INPUT, 0, 2, 16'shFFFF);
    queue_fields(CMD_WR_INPUT, 63, 63, 16'sh5555);
    queue_fields(CMD_UNUSED, 63, 63, 16'shFFFF);
    queue_fields(CMD_UNUSED, 0, 0, '0);
    queue_fields(CMD_RUN, 0, 0, '0);
    queue_fields(CMD_WR_INPUT, 0, 0, '0);
    queue_fields(CMD_WR_INPUT, 0, 1, '0);
    queue_fields(CMD_RUN, 63, 63, 16'shFFFF);      // zero sum
    queue_fields(CMD_WR_INPUT, 0, 0, 16'sd1);
    queue_fields(CMD_WR_WEIGHT, 0, 0, 16'sd1);
    queue_fields(CMD_RUN, 0, 0, '0);              // smallest nonzero sum on neuron 0
    drain();

    // Register extremes: widest, tallest, empty, oversized; then random sizes
    run_phase(64, 1, 10, 10);
    run_phase(1, 64, 10, 20);
    run_phase(0, 3, 10, 10);
    run_phase(6, 0, 10, 10);
    run_phase(127, 1, 10, 15);
    run_phase(1, 100, 10, 0);
    repeat (2)
      run_phase($urandom_range(1, 12), $urandom_range(1, 8), 25, $urandom_range(0, 30));
    run_phase($urandom_range(1, 12), $urandom_range(1, 8), 20, 0);

    mismatches += expected_acts.size();
    $display("Covered %0d requests with %0d layer runs over %0d register settings;",
             n_accepted, n_runs, n_settings);
    $display("%0d neuron results compared, %0d wrong or missing.", n_results, mismatches);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
